// ===== hdl/ise_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_pkg: shared types for the insertion sort engine
// Controller states and the command/status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ise_pkg;

	// Controller states
	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic insert;   // insert the incoming value into the sorted row
		logic shift;    // drop the head entry, move the row down one place
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic full;     // row holds its maximum number of entries
		logic one_left; // exactly one entry remains
	} status_t;

endpackage

// ===== hdl/ise_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_ctrl: controller for the insertion sort engine
// Loads elements until the final one of a list, then streams the sorted
// list out and returns to loading.
// ----------------------------------------------------------------------------
module ise_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             is_last,
	output logic             out_valid,
	input  logic             out_stall,
	output ise_pkg::cmd_t    cmd,
	input  ise_pkg::status_t status
);

	ise_pkg::state_t state_q;
	ise_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ise_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		in_stall   = 1'b1;
		out_valid  = 1'b0;
		cmd.insert = 1'b0;
		cmd.shift  = 1'b0;
		unique case (state_q)
			ise_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.insert = 1'b1;
					if (is_last) begin
						state_nxt = ise_pkg::ST_EMIT;
					end
				end
			end
			ise_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.shift = 1'b1;
					if (status.one_left) begin
						state_nxt = ise_pkg::ST_LOAD;
					end
				end
			end
			default: begin
				state_nxt = ise_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

// ===== hdl/ise_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_datapath: sorted row of cells for the insertion sort engine
// Every cell compares its entry with the incoming value at once; cells above
// the insertion point move up one place. Emission shifts the row down.
// ----------------------------------------------------------------------------
module ise_datapath #(
	parameter int MAX_ITEMS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ise_pkg::cmd_t      cmd,
	output ise_pkg::status_t   status,
	input  logic signed [31:0] item_value,
	output logic signed [31:0] sorted_value,
	output logic               last_out,
	output logic               overflowed
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic signed [31:0] cell_q [MAX_ITEMS];
	logic [CNT_W-1:0]   count_q;
	logic               drop_q;
	logic [MAX_ITEMS-1:0] gt;   // entry moves or slot takes the new value

	// Status toward the controller
	assign status.full     = (count_q == CNT_W'(MAX_ITEMS));
	assign status.one_left = (count_q == CNT_W'(1));

	// Value from the head cell; flags from the count and drop_q
	assign sorted_value = cell_q[0];
	assign last_out     = status.one_left;
	assign overflowed   = drop_q;

	// Per-cell compare: empty slots count as greater
	genvar i;
	generate
		for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
			logic signed [31:0] ins_val;

			assign gt[i] = (CNT_W'(i) >= count_q) || (cell_q[i] > item_value);

			// Value taken on insert: neighbor below moves up, or new value lands
			if (i == 0) begin : g_head
				assign ins_val = item_value;
			end else begin : g_body
				assign ins_val = gt[i-1] ? cell_q[i-1] : item_value;
			end

			always_ff @(posedge clk) begin
				if (cmd.insert && !status.full && gt[i]) begin
					cell_q[i] <= ins_val;
				end else if (cmd.shift) begin
					if (i < MAX_ITEMS - 1) begin
						cell_q[i] <= cell_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
					end
				end
			end
		end
	endgenerate

	// Entry count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			if (cmd.insert) begin
				if (status.full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (cmd.shift) begin
				count_q <= count_q - CNT_W'(1);
				if (status.one_left) begin
					drop_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== hdl/insertion_sort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_engine: streaming sorter for lists of signed 32-bit values
// Top level joining the controller and the sorted-row datapath.
// ----------------------------------------------------------------------------
// Elements arrive one per request; each is placed into a row of MAX_ITEMS
// cells at once, since every cell compares with the new value in parallel,
// so the next element can be taken right away. Equal values keep arrival
// order. The request with is_last set starts emission: the list leaves in
// ascending order from the head cell, one result per cycle while out_stall
// is low, and the input is stalled until the last result, marked by
// last_out, is taken. Elements beyond MAX_ITEMS are dropped and every
// result of that list carries overflowed.
module insertion_sort_engine #(
	parameter int MAX_ITEMS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] item_value,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] sorted_value,
	output logic               last_out,
	output logic               overflowed
);

	ise_pkg::cmd_t    cmd;
	ise_pkg::status_t status;

	// Controller
	ise_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Sorted row
	ise_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item_value   (item_value),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflowed   (overflowed)
	);

endmodule
